FILE: design/ebcpu_pkg.sv
// Package with shared types and constants of the 8-bit CPU core.
package ebcpu_pkg;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_EXEC   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [7:0] FLAG_Z = 8'h80;
  localparam logic [7:0] FLAG_N = 8'h40;
  localparam logic [7:0] FLAG_H = 8'h20;
  localparam logic [7:0] FLAG_C = 8'h10;
  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

  localparam logic [7:0] OP_NOP     = 8'h00;
  localparam logic [7:0] OP_LD_BC   = 8'h01;
  localparam logic [7:0] OP_DECR_B  = 8'h05;
  localparam logic [7:0] OP_LD_B    = 8'h06;
  localparam logic [7:0] OP_DECR_BC = 8'h0B;
  localparam logic [7:0] OP_INCR_C  = 8'h0C;
  localparam logic [7:0] OP_DECR_C  = 8'h0D;
  localparam logic [7:0] OP_LD_C    = 8'h0E;
  localparam logic [7:0] OP_JR_NZ   = 8'h20;
  localparam logic [7:0] OP_LD_HL   = 8'h21;
  localparam logic [7:0] OP_ST_HLI  = 8'h22;
  localparam logic [7:0] OP_LD_AHLI = 8'h2A;
  localparam logic [7:0] OP_LD_SP   = 8'h31;
  localparam logic [7:0] OP_ST_HLD  = 8'h32;
  localparam logic [7:0] OP_ST_HLN  = 8'h36;
  localparam logic [7:0] OP_LD_A    = 8'h3E;
  localparam logic [7:0] OP_ST_HLA  = 8'h77;
  localparam logic [7:0] OP_LD_AB   = 8'h78;
  localparam logic [7:0] OP_CLR_A   = 8'hAF;
  localparam logic [7:0] OP_OR_C    = 8'hB1;
  localparam logic [7:0] OP_JP      = 8'hC3;
  localparam logic [7:0] OP_CALL    = 8'hCD;
  localparam logic [7:0] OP_LDH_ST  = 8'hE0;
  localparam logic [7:0] OP_ST_C    = 8'hE2;
  localparam logic [7:0] OP_ST_A16  = 8'hEA;
  localparam logic [7:0] OP_LDH_LD  = 8'hF0;
  localparam logic [7:0] OP_LD_A16  = 8'hFA;
  localparam logic [7:0] OP_CP      = 8'hFE;
  localparam logic [7:0] OP_UNIMPL  = 8'hFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] pc_out;
    logic [15:0] sp_out;
    logic [7:0]  a_out;
    logic [7:0]  f_out;
    logic [7:0]  b_out;
    logic [7:0]  c_out;
    logic [7:0]  h_out;
    logic [7:0]  l_out;
    logic [4:0]  cycle_cost;
    logic        invalid_opcode;
  } out_item_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_OP    = 7'b0000010,
    ST_IMM1  = 7'b0000100,
    ST_IMM2  = 7'b0001000,
    ST_EXEC  = 7'b0010000,
    ST_MEM2  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

endpackage

FILE: design/ebcpu_if.sv
// Valid/ready channel interfaces for the input and result items.
interface ebcpu_in_if;
  logic valid;
  logic ready;
  ebcpu_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ebcpu_out_if;
  logic valid;
  logic ready;
  ebcpu_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/eight_bit_cpu_opcode_subset.sv
// Top level of the 8-bit CPU core: sequencer, register file and byte memory.
// One item is taken at a time. A memory write or read passes from ST_IDLE to ST_DONE, which
// registers its result; an instruction always fetches three bytes and then executes, passing
// ST_OP, ST_IMM1, ST_IMM2, ST_EXEC and ST_DONE, with ST_MEM2 added for CALL, whose second
// push byte needs one more use of the single-port byte memory. The input is ready again the
// cycle after the result transfers, so no new item is taken before the last result has gone.
// Memory is not cleared.
module eight_bit_cpu_opcode_subset #(
  parameter int MEM_ADDR_BITS = 16
) (
  input logic clk,
  input logic rst_n,
  ebcpu_in_if.sink    in_ch,
  ebcpu_out_if.source out_ch
);
  localparam int Depth = 1 << MEM_ADDR_BITS;

  ebcpu_pkg::state_t state_r, state_nxt;
  ebcpu_pkg::in_item_t item_r;
  ebcpu_pkg::out_item_t res_r, res_nxt;
  logic res_valid_r, res_valid_nxt;
  logic [7:0] a_r, f_r, b_r, c_r, h_r, l_r;
  logic [7:0] a_nxt, f_nxt, b_nxt, c_nxt, h_nxt, l_nxt;
  logic [15:0] sp_r, pc_r, sp_nxt, pc_nxt;
  logic [7:0] op_r, op_nxt, imm1_r, imm1_nxt;
  logic [4:0] cost;
  logic bad;
  logic [1:0] nbytes;

  logic mem_we;
  logic [15:0] mem_addr16;
  logic [7:0] mem_wdata, mem_rdata;

  // In ST_MEM2 of CALL sp_r already holds SP-2 and pc_r the target, so PC+3
  // is rebuilt from a saved copy.
  logic [15:0] pc_save_r;
  logic [15:0] call_pc3;
  assign call_pc3 = pc_save_r + 16'd3;

  ebcpu_ram #(.WIDTH(8), .DEPTH(Depth)) u_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr16[MEM_ADDR_BITS-1:0]),
    .wdata(mem_wdata), .rdata(mem_rdata)
  );

  logic accept;
  assign in_ch.ready = (state_r == ebcpu_pkg::ST_IDLE) && !res_valid_r;
  assign accept = in_ch.valid && in_ch.ready;
  assign out_ch.valid = res_valid_r;
  assign out_ch.payload = res_r;

  logic [15:0] hl, bc, imm16, pc1, pc2, pc3;
  logic [7:0] opc;
  assign hl = {h_r, l_r};
  assign bc = {b_r, c_r};
  assign imm16 = {mem_rdata, imm1_r};
  assign pc1 = pc_r + 16'd1;
  assign pc2 = pc_r + 16'd2;
  assign pc3 = pc_r + 16'd3;
  assign opc = op_r;

  always_comb begin
    unique case (opc)
      ebcpu_pkg::OP_LD_BC, ebcpu_pkg::OP_LD_HL, ebcpu_pkg::OP_LD_SP, ebcpu_pkg::OP_JP,
      ebcpu_pkg::OP_CALL, ebcpu_pkg::OP_ST_A16, ebcpu_pkg::OP_LD_A16: nbytes = 2'd3;
      ebcpu_pkg::OP_LD_B, ebcpu_pkg::OP_LD_C, ebcpu_pkg::OP_JR_NZ, ebcpu_pkg::OP_ST_HLN,
      ebcpu_pkg::OP_LD_A, ebcpu_pkg::OP_LDH_ST, ebcpu_pkg::OP_LDH_LD,
      ebcpu_pkg::OP_CP: nbytes = 2'd2;
      default: nbytes = 2'd1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    res_nxt = res_r;
    res_valid_nxt = res_valid_r;
    a_nxt = a_r; f_nxt = f_r; b_nxt = b_r; c_nxt = c_r; h_nxt = h_r; l_nxt = l_r;
    sp_nxt = sp_r; pc_nxt = pc_r;
    op_nxt = op_r; imm1_nxt = imm1_r;
    mem_we = 1'b0; mem_addr16 = pc_r; mem_wdata = a_r;
    cost = 5'd0; bad = 1'b0;
    if (res_valid_r && out_ch.ready) begin
      res_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ebcpu_pkg::ST_IDLE: begin
        mem_addr16 = (in_ch.payload.command == ebcpu_pkg::CMD_EXEC) ?
                     pc_r : in_ch.payload.address;
        mem_we = accept && (in_ch.payload.command == ebcpu_pkg::CMD_WRITE);
        mem_wdata = in_ch.payload.data;
        if (accept) begin
          state_nxt = (in_ch.payload.command == ebcpu_pkg::CMD_EXEC) ?
                      ebcpu_pkg::ST_OP : ebcpu_pkg::ST_DONE;
        end
      end
      ebcpu_pkg::ST_OP: begin
        op_nxt = mem_rdata;
        mem_addr16 = pc1;
        state_nxt = ebcpu_pkg::ST_IMM1;
      end
      ebcpu_pkg::ST_IMM1: begin
        imm1_nxt = mem_rdata;
        mem_addr16 = pc2;
        state_nxt = ebcpu_pkg::ST_IMM2;
      end
      ebcpu_pkg::ST_IMM2: begin
        unique case (op_r)
          ebcpu_pkg::OP_ST_HLI, ebcpu_pkg::OP_ST_HLD, ebcpu_pkg::OP_ST_HLA,
          ebcpu_pkg::OP_LD_AHLI: mem_addr16 = hl;
          ebcpu_pkg::OP_LDH_LD: mem_addr16 = ebcpu_pkg::HIGH_PAGE + {8'h00, imm1_r};
          ebcpu_pkg::OP_LD_A16: mem_addr16 = imm16;
          default: mem_addr16 = pc2;
        endcase
        state_nxt = ebcpu_pkg::ST_EXEC;
      end
      ebcpu_pkg::ST_EXEC: begin
        state_nxt = ebcpu_pkg::ST_DONE;
        pc_nxt = (nbytes == 2'd3) ? pc3 : (nbytes == 2'd2) ? pc2 : pc1;
        unique case (op_r)
          ebcpu_pkg::OP_NOP: cost = 5'd4;
          ebcpu_pkg::OP_LD_BC: begin b_nxt = mem_rdata; c_nxt = imm1_r; cost = 5'd12; end
          ebcpu_pkg::OP_DECR_B, ebcpu_pkg::OP_DECR_C: begin
            logic [7:0] v;
            v = (op_r == ebcpu_pkg::OP_DECR_B) ? b_r : c_r;
            f_nxt = (f_r & ebcpu_pkg::FLAG_C) | ebcpu_pkg::FLAG_N |
                    ((v[3:0] == 4'h0) ? ebcpu_pkg::FLAG_H : 8'h00) |
                    ((v == 8'h01) ? ebcpu_pkg::FLAG_Z : 8'h00);
            if (op_r == ebcpu_pkg::OP_DECR_B) b_nxt = v - 8'd1;
            else c_nxt = v - 8'd1;
            cost = 5'd4;
          end
          ebcpu_pkg::OP_LD_B: begin b_nxt = imm1_r; cost = 5'd8; end
          ebcpu_pkg::OP_DECR_BC: begin {b_nxt, c_nxt} = bc - 16'd1; cost = 5'd8; end
          ebcpu_pkg::OP_INCR_C: begin
            f_nxt = (f_r & ebcpu_pkg::FLAG_C) |
                    ((c_r[3:0] == 4'hF) ? ebcpu_pkg::FLAG_H : 8'h00) |
                    ((c_r == 8'hFF) ? ebcpu_pkg::FLAG_Z : 8'h00);
            c_nxt = c_r + 8'd1;
            cost = 5'd4;
          end
          ebcpu_pkg::OP_LD_C: begin c_nxt = imm1_r; cost = 5'd8; end
          ebcpu_pkg::OP_JR_NZ: begin
            if ((f_r & ebcpu_pkg::FLAG_Z) == 8'h00) begin
              pc_nxt = pc2 + {{8{imm1_r[7]}}, imm1_r};
              cost = 5'd12;
            end else begin
              cost = 5'd8;
            end
          end
          ebcpu_pkg::OP_LD_HL: begin h_nxt = mem_rdata; l_nxt = imm1_r; cost = 5'd12; end
          ebcpu_pkg::OP_ST_HLI: begin
            mem_we = 1'b1; mem_addr16 = hl; {h_nxt, l_nxt} = hl + 16'd1; cost = 5'd8;
          end
          ebcpu_pkg::OP_LD_AHLI: begin
            a_nxt = mem_rdata; {h_nxt, l_nxt} = hl + 16'd1; cost = 5'd8;
          end
          ebcpu_pkg::OP_LD_SP: begin sp_nxt = imm16; cost = 5'd12; end
          ebcpu_pkg::OP_ST_HLD: begin
            mem_we = 1'b1; mem_addr16 = hl; {h_nxt, l_nxt} = hl - 16'd1; cost = 5'd8;
          end
          ebcpu_pkg::OP_ST_HLN: begin
            mem_we = 1'b1; mem_addr16 = hl; mem_wdata = imm1_r; cost = 5'd12;
          end
          ebcpu_pkg::OP_LD_A: begin a_nxt = imm1_r; cost = 5'd8; end
          ebcpu_pkg::OP_ST_HLA: begin mem_we = 1'b1; mem_addr16 = hl; cost = 5'd8; end
          ebcpu_pkg::OP_LD_AB: begin a_nxt = b_r; cost = 5'd4; end
          ebcpu_pkg::OP_CLR_A: begin a_nxt = 8'h00; f_nxt = ebcpu_pkg::FLAG_Z; cost = 5'd4; end
          ebcpu_pkg::OP_OR_C: begin
            a_nxt = a_r | c_r;
            f_nxt = ((a_r | c_r) == 8'h00) ? ebcpu_pkg::FLAG_Z : 8'h00;
            cost = 5'd4;
          end
          ebcpu_pkg::OP_JP: begin pc_nxt = imm16; cost = 5'd16; end
          ebcpu_pkg::OP_CALL: begin
            mem_we = 1'b1; mem_addr16 = sp_r - 16'd1; mem_wdata = pc3[15:8];
            pc_nxt = imm16; sp_nxt = sp_r - 16'd2; cost = 5'd24;
            state_nxt = ebcpu_pkg::ST_MEM2;
          end
          ebcpu_pkg::OP_LDH_ST: begin
            mem_we = 1'b1; mem_addr16 = ebcpu_pkg::HIGH_PAGE + {8'h00, imm1_r}; cost = 5'd12;
          end
          ebcpu_pkg::OP_ST_C: begin
            mem_we = 1'b1; mem_addr16 = ebcpu_pkg::HIGH_PAGE + {8'h00, c_r}; cost = 5'd8;
          end
          ebcpu_pkg::OP_ST_A16: begin mem_we = 1'b1; mem_addr16 = imm16; cost = 5'd16; end
          ebcpu_pkg::OP_LDH_LD: begin a_nxt = mem_rdata; cost = 5'd12; end
          ebcpu_pkg::OP_LD_A16: begin a_nxt = mem_rdata; cost = 5'd16; end
          ebcpu_pkg::OP_CP: begin
            f_nxt = ebcpu_pkg::FLAG_N |
                    ((a_r == imm1_r) ? ebcpu_pkg::FLAG_Z : 8'h00) |
                    ((a_r[3:0] < imm1_r[3:0]) ? ebcpu_pkg::FLAG_H : 8'h00) |
                    ((a_r < imm1_r) ? ebcpu_pkg::FLAG_C : 8'h00);
            cost = 5'd8;
          end
          default: begin
            bad = 1'b1;
            pc_nxt = pc_r;
          end
        endcase
        res_nxt.read_data = 8'h00;
        res_nxt.cycle_cost = cost;
        res_nxt.invalid_opcode = bad;
      end
      ebcpu_pkg::ST_MEM2: begin
        // ST_MEM2 of CALL pushes the low byte of the return address.
        state_nxt = ebcpu_pkg::ST_DONE;
        mem_we = 1'b1; mem_addr16 = sp_r; mem_wdata = call_pc3[7:0];
      end
      ebcpu_pkg::ST_DONE: begin
        if (item_r.command == ebcpu_pkg::CMD_READ) res_nxt.read_data = mem_rdata;
        else if (item_r.command != ebcpu_pkg::CMD_EXEC) res_nxt.read_data = 8'h00;
        if (item_r.command != ebcpu_pkg::CMD_EXEC) begin
          res_nxt.cycle_cost = 5'd0;
          res_nxt.invalid_opcode = 1'b0;
        end
        res_nxt.pc_out = pc_r; res_nxt.sp_out = sp_r;
        res_nxt.a_out = a_r; res_nxt.f_out = f_r; res_nxt.b_out = b_r;
        res_nxt.c_out = c_r; res_nxt.h_out = h_r; res_nxt.l_out = l_r;
        res_valid_nxt = 1'b1;
        state_nxt = ebcpu_pkg::ST_IDLE;
      end
      default: state_nxt = ebcpu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ebcpu_pkg::ST_IDLE;
      res_valid_r <= 1'b0;
      a_r <= '0; f_r <= '0; b_r <= '0; c_r <= '0; h_r <= '0; l_r <= '0;
      sp_r <= '0; pc_r <= '0;
    end else begin
      state_r <= state_nxt;
      res_valid_r <= res_valid_nxt;
      a_r <= a_nxt; f_r <= f_nxt; b_r <= b_nxt; c_r <= c_nxt; h_r <= h_nxt; l_r <= l_nxt;
      sp_r <= sp_nxt; pc_r <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    op_r <= op_nxt;
    imm1_r <= imm1_nxt;
    if (accept) item_r <= in_ch.payload;
    if (state_r == ebcpu_pkg::ST_EXEC) pc_save_r <= pc_r;
  end

  // The low push byte must equal the saved return address.
  property p_call_low;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ebcpu_pkg::ST_MEM2 && op_r == ebcpu_pkg::OP_CALL) |->
        (mem_wdata == call_pc3[7:0]);
  endproperty
  a_call_low: assert property (p_call_low) else $error("CALL low push byte wrong");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == ebcpu_pkg::ST_IDLE && !out_ch.valid))
    else $error("input ready while busy");

  a_bad_cost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload.invalid_opcode) |-> (out_ch.payload.cycle_cost == 5'd0))
    else $error("invalid opcode with nonzero cost");

  a_f_low: assert property (@(posedge clk) disable iff (!rst_n)
    f_r[3:0] == 4'h0) else $error("low flag bits set");
endmodule

FILE: design/ebcpu_ram.sv
// Generic single-port RAM with registered read data.
module ebcpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
